// ----- hw/rtl/ofb_pkg.sv -----
// ----------------------------------------------------------------------------
// ofb_pkg
// Shared types and constants for the octant front-to-back order unit.
// ----------------------------------------------------------------------------
package ofb_pkg;

  localparam int COORD_WIDTH     = 24;
  localparam int NUM_OCT         = 8;
  localparam int NUM_STEPS       = 28;
  localparam int NET_STAGES      = 4;
  localparam int STEPS_PER_STAGE = NUM_STEPS / NET_STAGES;

  typedef logic [2:0]                   ofb_oct_t;
  typedef ofb_oct_t [NUM_OCT-1:0]       ofb_order_t;
  typedef logic [NUM_OCT-1:0][NUM_OCT-1:0] ofb_gt_t;

  // gt[a][b] set when the key of octant a is strictly above the key of octant b
  typedef struct packed {
    ofb_gt_t    gt;
    ofb_order_t order;
  } ofb_net_t;

  // compare-exchange schedule: position pairs in network order
  localparam ofb_oct_t STEP_A [NUM_STEPS] = '{
    3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
    3'd3, 3'd3, 3'd3, 3'd3,
    3'd4, 3'd4, 3'd4,
    3'd5, 3'd5,
    3'd6
  };

  localparam ofb_oct_t STEP_B [NUM_STEPS] = '{
    3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
    3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
    3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
    3'd4, 3'd5, 3'd6, 3'd7,
    3'd5, 3'd6, 3'd7,
    3'd6, 3'd7,
    3'd7
  };

endpackage

// ----- hw/rtl/ofb_if.sv -----
// ----------------------------------------------------------------------------
// ofb_if
// Valid/ready channels for node transactions and order transactions.
// ----------------------------------------------------------------------------
interface ofb_node_if #(
  parameter int COORD_WIDTH = ofb_pkg::COORD_WIDTH
) ();
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] cam_x;
  logic signed [COORD_WIDTH-1:0] cam_y;
  logic signed [COORD_WIDTH-1:0] cam_z;
  logic signed [COORD_WIDTH-1:0] lo_x;
  logic signed [COORD_WIDTH-1:0] lo_y;
  logic signed [COORD_WIDTH-1:0] lo_z;
  logic signed [COORD_WIDTH-1:0] mid_x;
  logic signed [COORD_WIDTH-1:0] mid_y;
  logic signed [COORD_WIDTH-1:0] mid_z;
  logic signed [COORD_WIDTH-1:0] hi_x;
  logic signed [COORD_WIDTH-1:0] hi_y;
  logic signed [COORD_WIDTH-1:0] hi_z;

  modport source (
    output valid, cam_x, cam_y, cam_z, lo_x, lo_y, lo_z,
           mid_x, mid_y, mid_z, hi_x, hi_y, hi_z,
    input  ready
  );
  modport sink (
    input  valid, cam_x, cam_y, cam_z, lo_x, lo_y, lo_z,
           mid_x, mid_y, mid_z, hi_x, hi_y, hi_z,
    output ready
  );
endinterface

interface ofb_order_if ();
  logic       valid;
  logic       ready;
  logic [2:0] rank0_octant;
  logic [2:0] rank1_octant;
  logic [2:0] rank2_octant;
  logic [2:0] rank3_octant;
  logic [2:0] rank4_octant;
  logic [2:0] rank5_octant;
  logic [2:0] rank6_octant;
  logic [2:0] rank7_octant;

  modport source (
    output valid, rank0_octant, rank1_octant, rank2_octant, rank3_octant,
           rank4_octant, rank5_octant, rank6_octant, rank7_octant,
    input  ready
  );
  modport sink (
    input  valid, rank0_octant, rank1_octant, rank2_octant, rank3_octant,
           rank4_octant, rank5_octant, rank6_octant, rank7_octant,
    output ready
  );
endinterface

// ----- hw/rtl/ofb_key.sv -----
// ----------------------------------------------------------------------------
// ofb_key
// Three-stage key pipeline: doubled axis offsets, squares, octant keys.
// ----------------------------------------------------------------------------
module ofb_key #(
  parameter int COORD_WIDTH = ofb_pkg::COORD_WIDTH
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  ofb_node_if.sink                                     in_node,
  output logic                                         out_vld,
  input  logic                                         out_rdy,
  output logic [2*(COORD_WIDTH+2)-1:0]                 key_o [ofb_pkg::NUM_OCT]
);

  localparam int DW = COORD_WIDTH + 2;
  localparam int KW = 2 * DW;

  logic signed [COORD_WIDTH-1:0] cam [3];
  logic signed [COORD_WIDTH-1:0] lo  [3];
  logic signed [COORD_WIDTH-1:0] mid [3];
  logic signed [COORD_WIDTH-1:0] hi  [3];

  logic [DW-1:0] abs_nxt [3][2];
  logic [DW-1:0] abs_r   [3][2];
  logic [1:0]    ins_nxt [3];
  logic [1:0]    ins1_r  [3];
  logic [KW-1:0] sq_nxt  [3][2];
  logic [KW-1:0] sq_r    [3][2];
  logic [1:0]    ins2_r  [3];
  logic [KW-1:0] key_nxt [ofb_pkg::NUM_OCT];
  logic [KW-1:0] key_r   [ofb_pkg::NUM_OCT];

  logic v1_r, v2_r, v3_r;
  logic adv1, adv2, adv3;

  assign cam[0] = in_node.cam_x;
  assign cam[1] = in_node.cam_y;
  assign cam[2] = in_node.cam_z;
  assign lo[0]  = in_node.lo_x;
  assign lo[1]  = in_node.lo_y;
  assign lo[2]  = in_node.lo_z;
  assign mid[0] = in_node.mid_x;
  assign mid[1] = in_node.mid_y;
  assign mid[2] = in_node.mid_z;
  assign hi[0]  = in_node.hi_x;
  assign hi[1]  = in_node.hi_y;
  assign hi[2]  = in_node.hi_z;

  assign adv3          = !v3_r || out_rdy;
  assign adv2          = !v2_r || adv3;
  assign adv1          = !v1_r || adv2;
  assign in_node.ready = adv1;
  assign out_vld       = v3_r;

  // stage 1: d = 2*cam - (omin + omax) per axis and half, plus containment
  always_comb begin
    logic signed [DW-1:0] c2, le, me, he, dl, dh;
    for (int a = 0; a < 3; a++) begin
      c2 = {cam[a][COORD_WIDTH-1], cam[a], 1'b0};
      le = {{2{lo[a][COORD_WIDTH-1]}}, lo[a]};
      me = {{2{mid[a][COORD_WIDTH-1]}}, mid[a]};
      he = {{2{hi[a][COORD_WIDTH-1]}}, hi[a]};
      dl = c2 - le - me;
      dh = c2 - me - he;
      abs_nxt[a][0] = dl[DW-1] ? DW'(-dl) : DW'(dl);
      abs_nxt[a][1] = dh[DW-1] ? DW'(-dh) : DW'(dh);
      ins_nxt[a][0] = (cam[a] >= lo[a])  && (cam[a] <= mid[a]);
      ins_nxt[a][1] = (cam[a] >= mid[a]) && (cam[a] <= hi[a]);
    end
  end

  // stage 2: squares
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int h = 0; h < 2; h++) begin
        sq_nxt[a][h] = KW'(abs_r[a][h]) * KW'(abs_r[a][h]);
      end
    end
  end

  // stage 3: per-octant key, index bits y:x:z
  always_comb begin
    logic [2:0] o;
    for (int i = 0; i < ofb_pkg::NUM_OCT; i++) begin
      o = 3'(i);
      if (ins2_r[0][o[1]] && ins2_r[1][o[2]] && ins2_r[2][o[0]]) begin
        key_nxt[i] = '0;
      end else begin
        key_nxt[i] = sq_r[0][o[1]] + sq_r[1][o[2]] + sq_r[2][o[0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_node.valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      abs_r  <= abs_nxt;
      ins1_r <= ins_nxt;
    end
    if (adv2) begin
      sq_r   <= sq_nxt;
      ins2_r <= ins1_r;
    end
    if (adv3) begin
      key_r  <= key_nxt;
    end
  end

  assign key_o = key_r;

endmodule

// ----- hw/rtl/ofb_cmp.sv -----
// ----------------------------------------------------------------------------
// ofb_cmp
// Pairwise key comparison stage; seeds the index order.
// ----------------------------------------------------------------------------
module ofb_cmp #(
  parameter int COORD_WIDTH = ofb_pkg::COORD_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_vld,
  output logic                         in_rdy,
  input  logic [2*(COORD_WIDTH+2)-1:0] key_i [ofb_pkg::NUM_OCT],
  output logic                         out_vld,
  input  logic                         out_rdy,
  output ofb_pkg::ofb_net_t            out_data
);

  ofb_pkg::ofb_net_t data_nxt, data_r;
  ofb_pkg::ofb_gt_t  gt_flip;
  logic              v_r;

  assign in_rdy = !v_r || out_rdy;

  always_comb begin
    data_nxt = '0;
    for (int a = 0; a < ofb_pkg::NUM_OCT; a++) begin
      data_nxt.order[a] = 3'(a);
      for (int b = 0; b < ofb_pkg::NUM_OCT; b++) begin
        data_nxt.gt[a][b] = key_i[a] > key_i[b];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_rdy) begin
      v_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy) data_r <= data_nxt;
  end

  assign out_vld  = v_r;
  assign out_data = data_r;

  always_comb begin
    for (int a = 0; a < ofb_pkg::NUM_OCT; a++) begin
      for (int b = 0; b < ofb_pkg::NUM_OCT; b++) begin
        gt_flip[a][b] = data_r.gt[b][a];
      end
    end
  end

  a_gt_antisym : assert property (@(posedge clk) disable iff (!rst_n)
    v_r |-> ((data_r.gt & gt_flip) == '0))
    else $error("comparison matrix not antisymmetric");

endmodule

// ----- hw/rtl/ofb_net.sv -----
// ----------------------------------------------------------------------------
// ofb_net
// One stage of the compare-exchange network, working on octant indices.
// ----------------------------------------------------------------------------
module ofb_net #(
  parameter int CHUNK = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  output logic              in_rdy,
  input  ofb_pkg::ofb_net_t in_data,
  output logic              out_vld,
  input  logic              out_rdy,
  output ofb_pkg::ofb_net_t out_data
);

  localparam int BASE = CHUNK * ofb_pkg::STEPS_PER_STAGE;

  ofb_pkg::ofb_net_t data_nxt, data_r;
  logic              v_r;

  assign in_rdy = !v_r || out_rdy;

  // swap positions when the earlier key is strictly greater
  always_comb begin
    ofb_pkg::ofb_oct_t ia, ib;
    data_nxt = in_data;
    for (int s = 0; s < ofb_pkg::STEPS_PER_STAGE; s++) begin
      ia = data_nxt.order[ofb_pkg::STEP_A[BASE+s]];
      ib = data_nxt.order[ofb_pkg::STEP_B[BASE+s]];
      if (in_data.gt[ia][ib]) begin
        data_nxt.order[ofb_pkg::STEP_A[BASE+s]] = ib;
        data_nxt.order[ofb_pkg::STEP_B[BASE+s]] = ia;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_rdy) begin
      v_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy) data_r <= data_nxt;
  end

  assign out_vld  = v_r;
  assign out_data = data_r;

  a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (v_r && !out_rdy) |=> (v_r && $stable(data_r)))
    else $error("network stage lost a stalled transaction");

endmodule

// ----- hw/rtl/octant_front_to_back_order_unit.sv -----
// ----------------------------------------------------------------------------
// octant_front_to_back_order_unit
// Orders the eight octants of an octree node nearest first from the camera.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle while out_order.ready is held high; 3 key
// stages, 1 compare stage and 4 network stages each hold one transaction and
// advance when the next is free.
// Reset clears the stage valid bits only; payload registers are not reset.
// ----------------------------------------------------------------------------
module octant_front_to_back_order_unit #(
  parameter int COORD_WIDTH = ofb_pkg::COORD_WIDTH
) (
  input  logic        clk,
  input  logic        rst_n,
  ofb_node_if.sink    in_node,
  ofb_order_if.source out_order
);

  localparam int NS = ofb_pkg::NET_STAGES;

  logic [2*(COORD_WIDTH+2)-1:0] key [ofb_pkg::NUM_OCT];
  logic                         key_vld, key_rdy;
  logic                         vld_c [NS+1];
  logic                         rdy_c [NS+1];
  ofb_pkg::ofb_net_t            dat_c [NS+1];
  ofb_pkg::ofb_order_t          ord;
  logic [ofb_pkg::NUM_OCT-1:0]  seen;

  ofb_key #(.COORD_WIDTH(COORD_WIDTH)) u_key (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_node (in_node),
    .out_vld (key_vld),
    .out_rdy (key_rdy),
    .key_o   (key)
  );

  ofb_cmp #(.COORD_WIDTH(COORD_WIDTH)) u_cmp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (key_vld),
    .in_rdy   (key_rdy),
    .key_i    (key),
    .out_vld  (vld_c[0]),
    .out_rdy  (rdy_c[0]),
    .out_data (dat_c[0])
  );

  for (genvar k = 0; k < NS; k++) begin : g_net
    ofb_net #(.CHUNK(k)) u_net (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (vld_c[k]),
      .in_rdy   (rdy_c[k]),
      .in_data  (dat_c[k]),
      .out_vld  (vld_c[k+1]),
      .out_rdy  (rdy_c[k+1]),
      .out_data (dat_c[k+1])
    );
  end

  assign ord                    = dat_c[NS].order;
  assign out_order.valid        = vld_c[NS];
  assign rdy_c[NS]              = out_order.ready;
  assign out_order.rank0_octant = ord[0];
  assign out_order.rank1_octant = ord[1];
  assign out_order.rank2_octant = ord[2];
  assign out_order.rank3_octant = ord[3];
  assign out_order.rank4_octant = ord[4];
  assign out_order.rank5_octant = ord[5];
  assign out_order.rank6_octant = ord[6];
  assign out_order.rank7_octant = ord[7];

  always_comb begin
    seen = '0;
    for (int r = 0; r < ofb_pkg::NUM_OCT; r++) begin
      seen[ord[r]] = 1'b1;
    end
  end

  a_order_perm : assert property (@(posedge clk) disable iff (!rst_n)
    out_order.valid |-> (seen == '1))
    else $error("order transaction is not a permutation of the octants");

endmodule
